>>> design/madt_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// madt_pkg
// Shared types and constants for the MADT record parser.
// -----------------------------------------------------------------------------
package madt_pkg;

   // Table capacities
   localparam int MAX_CPUS      = 64;
   localparam int MAX_IOAPICS   = 8;
   localparam int MAX_OVERRIDES = 16;

   // Record type codes
   localparam logic [7:0] REC_LAPIC          = 8'd0;
   localparam logic [7:0] REC_IOAPIC         = 8'd1;
   localparam logic [7:0] REC_ISO            = 8'd2;
   localparam logic [7:0] REC_LAPIC_OVERRIDE = 8'd5;

   // Result kind codes
   localparam logic [2:0] KIND_CPU      = 3'd0;
   localparam logic [2:0] KIND_IOAPIC   = 3'd1;
   localparam logic [2:0] KIND_OVERRIDE = 3'd2;
   localparam logic [2:0] KIND_ADDRESS  = 3'd3;
   localparam logic [2:0] KIND_SUMMARY  = 3'd4;

   // Preamble: four address bytes, four flag bytes
   localparam logic [3:0] PREAMBLE_LEN = 4'd8;
   // Record bytes captured past type and length
   localparam int CAPTURE_LEN = 10;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_table;
   } madt_req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  slot;
      logic [7:0]  ident;
      logic [7:0]  source_irq;
      logic [63:0] word_a;
      logic [31:0] word_b;
      logic [6:0]  cpu_total;
      logic [3:0]  ioapic_total;
      logic [4:0]  override_total;
      logic        last_of_run;
   } madt_rsp_type;

endpackage

>>> design/madt_record_parser_unit.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// madt_record_parser_unit
// Parses an MADT body byte by byte and reports CPUs, I/O APICs, interrupt
// overrides, address overrides and a closing summary.
// -----------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  req     | in  | req_valid / req_ready | madt_req_type (one byte, end mark)
//  rsp     | out | rsp_valid / rsp_ready | madt_rsp_type (one result)
//
//  One byte is taken per cycle; its results land in a four-entry output
//  queue in the same cycle and reach rsp in order, from the cycle after.
//  req_ready drops while fewer than two queue entries are free, since the
//  final byte of a record that closes the table gives two results.
//  Synchronous active-high reset clears parser state and empties the queue.
// -----------------------------------------------------------------------------
module madt_record_parser_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  madt_pkg::madt_req_type req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output madt_pkg::madt_rsp_type rsp_payload
);
   import madt_pkg::*;

   localparam int QDEPTH = 4;

   function automatic logic [31:0] le32(input logic [7:0] b0, input logic [7:0] b1,
                                        input logic [7:0] b2, input logic [7:0] b3);
      le32 = {b3, b2, b1, b0};
   endfunction

   // parser state
   logic [3:0]  preamble_pos_ff, preamble_pos_in;
   logic [63:0] apic_address_ff, apic_address_in;
   logic [7:0]  record_offset_ff, record_offset_in;
   logic [7:0]  record_type_ff, record_type_in;
   logic [7:0]  record_length_ff, record_length_in;
   logic [7:0]  record_bytes_ff [CAPTURE_LEN];
   logic [7:0]  record_bytes_in [CAPTURE_LEN];
   logic        stopped_ff, stopped_in;
   logic [6:0]  cpu_tally_ff, cpu_tally_in;
   logic [3:0]  ioapic_tally_ff, ioapic_tally_in;
   logic [4:0]  override_count_ff, override_count_in;

   // output queue
   madt_rsp_type queue_ff [QDEPTH];
   logic [1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [2:0]   fill_ff, fill_in;

   logic         req_fire, rsp_fire;
   logic         rec_done, rec_emit;
   logic [3:0]   cap_idx;
   madt_rsp_type rec_item, sum_item, push0, push1;
   logic [1:0]   push_n;

   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign req_ready = (fill_ff <= 3'(QDEPTH - 2));
   assign rsp_valid = (fill_ff != 3'd0);
   assign rsp_payload = queue_ff[rd_ptr_ff];
   assign cap_idx   = 4'(record_offset_ff - 8'd2);

   // Parse step for the incoming byte
   always_comb begin
      preamble_pos_in   = preamble_pos_ff;
      apic_address_in   = apic_address_ff;
      record_offset_in  = record_offset_ff;
      record_type_in    = record_type_ff;
      record_length_in  = record_length_ff;
      record_bytes_in   = record_bytes_ff;
      stopped_in        = stopped_ff;
      cpu_tally_in      = cpu_tally_ff;
      ioapic_tally_in   = ioapic_tally_ff;
      override_count_in = override_count_ff;
      rec_done          = 1'b0;
      rec_emit          = 1'b0;
      rec_item          = '0;

      if (!stopped_ff) begin
         if (preamble_pos_ff < PREAMBLE_LEN) begin
            if (!preamble_pos_ff[3] && !preamble_pos_ff[2]) begin
               apic_address_in = apic_address_ff |
                  (64'(req_payload.data_byte) << {preamble_pos_ff[1:0], 3'b000});
            end
            preamble_pos_in = preamble_pos_ff + 4'd1;
         end else if (record_offset_ff == 8'd0) begin
            record_type_in   = req_payload.data_byte;
            for (int i = 0; i < CAPTURE_LEN; i++) begin
               record_bytes_in[i] = 8'd0;
            end
            record_offset_in = 8'd1;
         end else if (record_offset_ff == 8'd1) begin
            record_length_in = req_payload.data_byte;
            if (req_payload.data_byte < 8'd2) begin
               stopped_in = 1'b1;
            end else if (req_payload.data_byte == 8'd2) begin
               rec_done         = 1'b1;
               record_offset_in = 8'd0;
            end else begin
               record_offset_in = 8'd2;
            end
         end else begin
            if (record_offset_ff < 8'd12) begin
               record_bytes_in[cap_idx] = req_payload.data_byte;
            end
            if ({1'b0, record_offset_ff} + 9'd1 >= {1'b0, record_length_ff}) begin
               rec_done         = 1'b1;
               record_offset_in = 8'd0;
            end else begin
               record_offset_in = record_offset_ff + 8'd1;
            end
         end
      end

      // Close the record: decode by type, respect table capacity
      if (rec_done) begin
         case (record_type_ff)
            REC_LAPIC: begin
               if ((record_bytes_in[2][1:0] != 2'b00) &&
                   ({1'b0, cpu_tally_ff} < 8'(MAX_CPUS))) begin
                  rec_emit       = 1'b1;
                  rec_item.kind  = KIND_CPU;
                  rec_item.slot  = 8'(cpu_tally_ff);
                  rec_item.ident = record_bytes_in[1];
                  cpu_tally_in   = cpu_tally_ff + 7'd1;
               end
            end
            REC_IOAPIC: begin
               if ({4'd0, ioapic_tally_ff} < 8'(MAX_IOAPICS)) begin
                  rec_emit        = 1'b1;
                  rec_item.kind   = KIND_IOAPIC;
                  rec_item.slot   = 8'(ioapic_tally_ff);
                  rec_item.ident  = record_bytes_in[0];
                  rec_item.word_a = 64'(le32(record_bytes_in[2], record_bytes_in[3],
                                             record_bytes_in[4], record_bytes_in[5]));
                  rec_item.word_b = le32(record_bytes_in[6], record_bytes_in[7],
                                         record_bytes_in[8], record_bytes_in[9]);
                  ioapic_tally_in = ioapic_tally_ff + 4'd1;
               end
            end
            REC_ISO: begin
               if ({3'd0, override_count_ff} < 8'(MAX_OVERRIDES)) begin
                  rec_emit            = 1'b1;
                  rec_item.kind       = KIND_OVERRIDE;
                  rec_item.slot       = 8'(override_count_ff);
                  rec_item.ident      = record_bytes_in[0];
                  rec_item.source_irq = record_bytes_in[1];
                  rec_item.word_a     = 64'(le32(record_bytes_in[2], record_bytes_in[3],
                                                 record_bytes_in[4], record_bytes_in[5]));
                  rec_item.word_b     = {16'd0, record_bytes_in[7], record_bytes_in[6]};
                  override_count_in   = override_count_ff + 5'd1;
               end
            end
            REC_LAPIC_OVERRIDE: begin
               rec_emit        = 1'b1;
               apic_address_in = {le32(record_bytes_in[6], record_bytes_in[7],
                                       record_bytes_in[8], record_bytes_in[9]),
                                  le32(record_bytes_in[2], record_bytes_in[3],
                                       record_bytes_in[4], record_bytes_in[5])};
               rec_item.kind   = KIND_ADDRESS;
               rec_item.word_a = apic_address_in;
            end
            default: begin
               rec_emit = 1'b0;
            end
         endcase
      end

      // Counts on every result reflect this byte's update
      rec_item.cpu_total      = cpu_tally_in;
      rec_item.ioapic_total   = ioapic_tally_in;
      rec_item.override_total = override_count_in;

      sum_item                = '0;
      sum_item.kind           = KIND_SUMMARY;
      sum_item.word_a         = apic_address_in;
      sum_item.cpu_total      = cpu_tally_in;
      sum_item.ioapic_total   = ioapic_tally_in;
      sum_item.override_total = override_count_in;
      sum_item.last_of_run    = 1'b1;

      // End mark: drop back to the start of a new table
      if (req_payload.end_of_table) begin
         preamble_pos_in   = '0;
         apic_address_in   = '0;
         record_offset_in  = '0;
         record_type_in    = '0;
         record_length_in  = '0;
         stopped_in        = 1'b0;
         cpu_tally_in      = '0;
         ioapic_tally_in   = '0;
         override_count_in = '0;
      end
   end

   // Queue push selection
   always_comb begin
      push0  = rec_emit ? rec_item : sum_item;
      push1  = sum_item;
      push_n = 2'(rec_emit) + 2'(req_payload.end_of_table);
      if (!req_fire) begin
         push_n = 2'd0;
      end
      fill_in = fill_ff + 3'(push_n) - 3'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         preamble_pos_ff   <= '0;
         apic_address_ff   <= '0;
         record_offset_ff  <= '0;
         record_type_ff    <= '0;
         record_length_ff  <= '0;
         stopped_ff        <= 1'b0;
         cpu_tally_ff      <= '0;
         ioapic_tally_ff   <= '0;
         override_count_ff <= '0;
      end else if (req_fire) begin
         preamble_pos_ff   <= preamble_pos_in;
         apic_address_ff   <= apic_address_in;
         record_offset_ff  <= record_offset_in;
         record_type_ff    <= record_type_in;
         record_length_ff  <= record_length_in;
         stopped_ff        <= stopped_in;
         cpu_tally_ff      <= cpu_tally_in;
         ioapic_tally_ff   <= ioapic_tally_in;
         override_count_ff <= override_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         record_bytes_ff <= record_bytes_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + push_n;
         rd_ptr_ff <= rd_ptr_ff + 2'(rsp_fire);
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= push0;
      end
      if (push_n == 2'd2) begin
         queue_ff[wr_ptr_ff + 2'd1] <= push1;
      end
   end

endmodule

>>> design/madt_record_parser_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// madt_record_parser_checker
// Port-level checks on the MADT record parser, bound to the top level.
// -----------------------------------------------------------------------------
module madt_record_parser_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input madt_pkg::madt_req_type req_payload,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input madt_pkg::madt_rsp_type rsp_payload
);
   import madt_pkg::*;

   // queue is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending right after reset");

   // a stalled result must stay offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before taken");

   // only the summary closes a run
   a_last_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_payload.kind == KIND_SUMMARY) == rsp_payload.last_of_run))
      else $error("last_of_run does not match summary kind");

   // a cpu's slot is one below the updated cpu count
   a_cpu_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.kind == KIND_CPU) |->
         ({1'b0, rsp_payload.cpu_total} == rsp_payload.slot + 8'd1))
      else $error("cpu slot out of step with cpu count");

   // counts never pass table capacity
   a_caps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_payload.cpu_total} <= 8'(MAX_CPUS)) &&
                    ({4'd0, rsp_payload.ioapic_total} <= 8'(MAX_IOAPICS)) &&
                    ({3'd0, rsp_payload.override_total} <= 8'(MAX_OVERRIDES)))
      else $error("count beyond table capacity");

endmodule

bind madt_record_parser_unit madt_record_parser_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
